>>> rtl/core/stp_pkg.sv
// shared types and constants of the symbol to word packer
package stp_pkg;

   localparam int DEF_MAX_WORD_BITS = 64;
   localparam int QUEUE_DEPTH       = 2;
   localparam int SYMBOL_W          = 8;
   localparam int CSR_DATA_W        = 8;
   localparam int CSR_INDEX_W       = 2;

   localparam logic [3:0] RESET_SYMBOL_BITS  = 4'd2;
   localparam logic [6:0] RESET_WORD_BITS    = 7'd64;
   localparam logic [7:0] RESET_SYMBOLS_PER_SIG = 8'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SYMBOL_BITS     = 2'd0,
      REG_WORD_BITS       = 2'd1,
      REG_SYMBOLS_PER_SIG = 2'd2
   } reg_index_type;

   // control bits that travel with each queued word
   typedef struct packed {
      logic closes;    // word ends a signature
      logic two;       // an all-zero terminator word follows
   } word_ctl_type;

endpackage

>>> rtl/core/symbol_to_word_packer.sv
// top level of the symbol to word packer
// a closed word passes the queue and the single output register on its way to rsp
// throughput: one symbol per cycle while the queue has room and one word per cycle
//   while rsp_ready is high; the terminator of a two-word symbol follows its word
// reset: synchronous, active high; registers return to 2-bit symbols, 64-bit words,
//   variable length signatures, and the open word, count and queue are cleared
module symbol_to_word_packer import stp_pkg::*; #(
   parameter int MAX_WORD_BITS = DEF_MAX_WORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration writes
   input  logic                     csr_write_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   // symbol input
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SYMBOL_W-1:0]      req_symbol,
   input  logic                     req_end_of_signature,
   // word output
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MAX_WORD_BITS-1:0] rsp_packed_word,
   output logic                     rsp_closes_signature,
   output logic                     rsp_last_of_run
);

   localparam int FILL_W  = $clog2(MAX_WORD_BITS + 1);
   localparam int CTL_W   = $bits(word_ctl_type);
   localparam int ENTRY_W = MAX_WORD_BITS + CTL_W;

   // front to queue
   logic                     q_push;
   logic [MAX_WORD_BITS-1:0] push_word;
   word_ctl_type             push_ctl;
   logic                     q_full;
   // queue to back
   logic                     q_pop;
   logic                     q_not_empty;
   logic [ENTRY_W-1:0]       pop_entry;
   word_ctl_type             pop_ctl;
   // right-align shift for the configured word width
   logic [FILL_W-1:0]        align_shift;

   // front end packs symbols left-aligned and decides which words close
   stp_front #(
      .MAX_WORD_BITS (MAX_WORD_BITS),
      .FILL_W        (FILL_W)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_symbol           (req_symbol),
      .req_end_of_signature (req_end_of_signature),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_word               (push_word),
      .q_ctl                (push_ctl),
      .align_shift          (align_shift)
   );

   // closed words wait here so input and output stall independently
   stp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_word, push_ctl}),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .pop_data  (pop_entry)
   );

   assign pop_ctl = word_ctl_type'(pop_entry[CTL_W-1:0]);

   // back end aligns each word and inserts the terminator word when needed
   stp_back #(
      .MAX_WORD_BITS (MAX_WORD_BITS),
      .FILL_W        (FILL_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_not_empty          (q_not_empty),
      .q_word               (pop_entry[ENTRY_W-1:CTL_W]),
      .q_ctl                (pop_ctl),
      .q_pop                (q_pop),
      .align_shift          (align_shift),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_packed_word      (rsp_packed_word),
      .rsp_closes_signature (rsp_closes_signature),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

>>> rtl/core/stp_front.sv
// front end: config registers, symbol packing and word closing
module stp_front import stp_pkg::*; #(
   parameter int MAX_WORD_BITS = DEF_MAX_WORD_BITS,
   parameter int FILL_W        = $clog2(MAX_WORD_BITS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SYMBOL_W-1:0]      req_symbol,
   input  logic                     req_end_of_signature,
   input  logic                     q_full,
   output logic                     q_push,
   output logic [MAX_WORD_BITS-1:0] q_word,
   output word_ctl_type             q_ctl,
   output logic [FILL_W-1:0]        align_shift
);

   logic [3:0]               sym_bits_ff;
   logic [6:0]               word_bits_ff;
   logic [7:0]               sym_per_sig_ff;
   logic [MAX_WORD_BITS-1:0] buf_ff, buf_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [7:0]               count_ff, count_in;

   logic [3:0]               sb_eff;
   logic [7:0]               wb_t;
   logic [FILL_W-1:0]        wb_eff;
   logic [7:0]               sym_m;
   logic [FILL_W-1:0]        fill_new;
   logic [FILL_W-1:0]        ins_pos;
   logic [MAX_WORD_BITS-1:0] buf_new;
   logic [7:0]               count_new;
   logic                     count_hit;
   logic                     close_fill;
   logic                     term;
   logic                     accept;
   logic                     csr_hit;

   // effective widths after clamping
   always_comb begin
      if (sym_bits_ff == 4'd0) begin
         sb_eff = 4'd1;
      end else if (sym_bits_ff > 4'd8) begin
         sb_eff = 4'd8;
      end else begin
         sb_eff = sym_bits_ff;
      end
      wb_t = {1'b0, word_bits_ff};
      if (wb_t < {4'd0, sb_eff}) begin
         wb_t = {4'd0, sb_eff};
      end
      if (wb_t > 8'(MAX_WORD_BITS)) begin
         wb_t = 8'(MAX_WORD_BITS);
      end
      wb_eff = FILL_W'(wb_t);
   end

   assign align_shift = FILL_W'(MAX_WORD_BITS) - wb_eff;

   // buffer is kept left-aligned, so padding and terminator bits are already zero
   assign sym_m    = req_symbol & 8'((9'd1 << sb_eff) - 9'd1);
   assign fill_new = fill_ff + FILL_W'(sb_eff);
   assign ins_pos  = FILL_W'(MAX_WORD_BITS) - fill_new;
   assign buf_new  = buf_ff | (MAX_WORD_BITS'(sym_m) << ins_pos);

   assign count_new  = count_ff + 8'd1;
   assign count_hit  = (sym_per_sig_ff != 8'd0) && (count_new == sym_per_sig_ff);
   assign close_fill = ({1'b0, fill_new} + (FILL_W + 1)'(sb_eff)) > {1'b0, wb_eff};
   assign term       = (sym_per_sig_ff == 8'd0) && req_end_of_signature;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign q_push     = accept && (count_hit || close_fill || term);
   assign q_word     = buf_new;
   assign q_ctl.closes = count_hit || (term && !(count_hit || close_fill));
   assign q_ctl.two    = (count_hit || close_fill) && term;

   always_comb begin
      buf_in   = buf_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (accept) begin
         if (count_hit || close_fill || term) begin
            buf_in  = '0;
            fill_in = '0;
         end else begin
            buf_in  = buf_new;
            fill_in = fill_new;
         end
         if (sym_per_sig_ff == 8'd0 || count_hit) begin
            count_in = 8'd0;
         end else begin
            count_in = count_new;
         end
      end
   end

   always_comb begin
      case (reg_index_type'(csr_index))
         REG_SYMBOL_BITS, REG_WORD_BITS, REG_SYMBOLS_PER_SIG: csr_hit = csr_write_en;
         default:                                            csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_bits_ff    <= RESET_SYMBOL_BITS;
         word_bits_ff   <= RESET_WORD_BITS;
         sym_per_sig_ff <= RESET_SYMBOLS_PER_SIG;
         buf_ff         <= '0;
         fill_ff        <= '0;
         count_ff       <= '0;
      end else if (csr_hit) begin
         case (reg_index_type'(csr_index))
            REG_SYMBOL_BITS:     sym_bits_ff    <= csr_data[3:0];
            REG_WORD_BITS:       word_bits_ff   <= csr_data[6:0];
            REG_SYMBOLS_PER_SIG: sym_per_sig_ff <= csr_data;
            default:             sym_bits_ff    <= sym_bits_ff;
         endcase
         buf_ff   <= '0;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         buf_ff   <= buf_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // an open word always has room for one more symbol
   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, fill_ff} + (FILL_W + 1)'(sb_eff)) <= {1'b0, wb_eff})
      else $error("open word cannot take another symbol");

   // the symbol count stays below the signature length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (sym_per_sig_ff == 8'd0) ? (count_ff == 8'd0) : (count_ff < sym_per_sig_ff))
      else $error("symbol count out of range");

endmodule

>>> rtl/core/stp_queue.sv
// small fifo between the packing front end and the output back end
module stp_queue import stp_pkg::*; #(
   parameter int WIDTH = 2,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             not_empty,
   output logic             full,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != CNT_W'(0));
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // no overflow and no underflow
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop) && !(pop && !not_empty))
      else $error("queue overflow or underflow");

endmodule

>>> rtl/core/stp_back.sv
// back end: output register, alignment and terminator word
module stp_back import stp_pkg::*; #(
   parameter int MAX_WORD_BITS = DEF_MAX_WORD_BITS,
   parameter int FILL_W        = $clog2(MAX_WORD_BITS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_not_empty,
   input  logic [MAX_WORD_BITS-1:0] q_word,
   input  word_ctl_type             q_ctl,
   output logic                     q_pop,
   input  logic [FILL_W-1:0]        align_shift,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [MAX_WORD_BITS-1:0] rsp_packed_word,
   output logic                     rsp_closes_signature,
   output logic                     rsp_last_of_run
);

   logic                     valid_ff, valid_in;
   logic                     term_pend_ff, term_pend_in;
   logic [MAX_WORD_BITS-1:0] word_ff, word_in;
   logic                     closes_ff, closes_in;
   logic                     last_ff, last_in;
   logic                     out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in     = valid_ff;
      term_pend_in = term_pend_ff;
      word_in      = word_ff;
      closes_in    = closes_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      if (out_free) begin
         if (term_pend_ff) begin
            valid_in     = 1'b1;
            term_pend_in = 1'b0;
            word_in      = '0;
            closes_in    = 1'b1;
            last_in      = 1'b1;
         end else if (q_not_empty) begin
            q_pop        = 1'b1;
            valid_in     = 1'b1;
            term_pend_in = q_ctl.two;
            word_in      = q_word >> align_shift;
            closes_in    = q_ctl.closes;
            last_in      = !q_ctl.two;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         term_pend_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         term_pend_ff <= term_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      closes_ff <= closes_in;
      last_ff   <= last_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_packed_word      = word_ff;
   assign rsp_closes_signature = closes_ff;
   assign rsp_last_of_run      = last_ff;

   // a pending terminator only follows a first word still on display
   a_term_after_word: assert property (@(posedge clock) disable iff (reset)
      term_pend_ff |-> (valid_ff && !last_ff))
      else $error("terminator pending without its first word");

   // a word that is not last of its run is always followed by the terminator
   a_not_last_pends: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff) |-> term_pend_ff)
      else $error("non-final word without pending terminator");

endmodule

>>> verif/symbol_to_word_packer_tb.sv
// self-checking testbench of the symbol to word packer
`timescale 1ns / 1ps

module symbol_to_word_packer_tb;
   import stp_pkg::*;

   // the csr index that no register answers to
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   // pipeline drain allowance before a register write and at the end
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 80;
   // lands in the 8-bit symbol, 8-bit word phase, where every symbol closes a word
   localparam int PRESSURE_AT   = 180;
   localparam int HOLD_CYCLES   = 150;

   // one row of the directed part: a register write or a symbol, with an
   // optional typed-in expectation (n_typed < 0 means use the predictor)
   typedef struct {
      bit                        is_csr;
      logic [CSR_INDEX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]     data;
      logic [SYMBOL_W-1:0]       sym;
      bit                        eos;
      int                        n_typed;
      logic [63:0]               w0;
      bit                        c0;
      logic [63:0]               w1;
      bit                        c1;
   } stim_row_type;

   typedef struct {
      logic [63:0] word;
      bit          closes;
      bit          last;
   } packed_word_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_en;
   logic [CSR_INDEX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;
   logic                          req_valid;
   logic                          req_ready;
   logic [SYMBOL_W-1:0]           req_symbol;
   logic                          req_end_of_signature;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [DEF_MAX_WORD_BITS-1:0]  rsp_packed_word;
   logic                          rsp_closes_signature;
   logic                          rsp_last_of_run;

   // row of the directed table that rides with the current word, -1 if random
   int cur_row;

   stim_row_type    stim_rows[$];
   packed_word_type expected_words[$];

   // predictor copy of the registers and the packing state
   logic [3:0]  cfg_sym_bits;
   logic [6:0]  cfg_word_bits;
   logic [7:0]  cfg_sig_len;
   logic [63:0] held_bits;
   int          fill;
   logic [7:0]  sig_count;

   int errors        = 0;
   int items_sent    = 0;
   int words_seen    = 0;
   int settings_used = 0;
   bit pressure_done = 0;

   symbol_to_word_packer uut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_symbol           (req_symbol),
      .req_end_of_signature (req_end_of_signature),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_packed_word      (rsp_packed_word),
      .rsp_closes_signature (rsp_closes_signature),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic logic [63:0] width_ones(input int w);
      if (w >= 64) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   // top-align the held bits in a word of wb bits, then empty the holder
   function automatic logic [63:0] close_word(input int wb);
      logic [63:0] w;
      w = '0;
      if (fill > 0 && fill <= wb) w = (held_bits << (wb - fill)) & width_ones(wb);
      held_bits = '0;
      fill      = 0;
      return w;
   endfunction

   function automatic void push_word(input logic [63:0] w, input bit closes, input bit last);
      packed_word_type pw;
      pw.word   = w;
      pw.closes = closes;
      pw.last   = last;
      expected_words.push_back(pw);
   endfunction

   function automatic void clear_packing();
      held_bits = '0;
      fill      = 0;
      sig_count = '0;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_SYMBOL_BITS:     cfg_sym_bits  = data[3:0];
         REG_WORD_BITS:       cfg_word_bits = data[6:0];
         REG_SYMBOLS_PER_SIG: cfg_sig_len   = data[7:0];
         default:             return;   // unused index leaves everything alone
      endcase
      // any real register write throws away the partial word
      clear_packing();
   endfunction

   // shift one symbol in and queue the words it closes
   function automatic void pack_symbol(input logic [SYMBOL_W-1:0] sym, input bit eos);
      int sb;
      int wb;
      int n0;
      bit hit;
      n0  = expected_words.size();
      hit = 0;
      // out-of-range widths are clamped, not rejected
      sb = (cfg_sym_bits == 0) ? 1 : (cfg_sym_bits > 8) ? 8 : int'(cfg_sym_bits);
      wb = int'(cfg_word_bits);
      if (wb < sb) wb = sb;
      if (wb > DEF_MAX_WORD_BITS) wb = DEF_MAX_WORD_BITS;

      held_bits = (held_bits << sb) | (64'(sym) & width_ones(sb));
      fill      = fill + sb;
      if (cfg_sig_len != 0) begin
         sig_count = sig_count + 8'd1;
         hit       = (sig_count == cfg_sig_len);
      end else begin
         sig_count = '0;
      end

      // close on count, or when the next symbol would overflow the word
      if (hit || fill + sb > wb) begin
         push_word(close_word(wb), hit, 1'b0);
         if (hit) sig_count = '0;
      end

      // variable mode: end flag appends a zero terminator and closes that word
      if (cfg_sig_len == 0 && eos) begin
         held_bits = held_bits << sb;
         fill      = fill + sb;
         push_word(close_word(wb), 1'b1, 1'b0);
      end

      if (expected_words.size() > n0) expected_words[$].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("[%0t] mismatch on %s: got %h, want %h (word %0d)",
               $realtime, what, got, want, words_seen);
      errors++;
   endtask

   // sample both channels at the edge; outputs were set by the block's own
   // nonblocking updates so the values read here are the ones at the edge
   always @(posedge clock) begin
      int n0;
      packed_word_type want;
      stim_row_type    r;
      if (reset) begin
         cfg_sym_bits  = RESET_SYMBOL_BITS;
         cfg_word_bits = RESET_WORD_BITS;
         cfg_sig_len   = RESET_SYMBOLS_PER_SIG;
         clear_packing();
      end else begin
         // compare before queuing new words so the oldest always goes first
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_packed_word, '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_packed_word !== want.word)
                  report_mismatch("packed_word", rsp_packed_word, want.word);
               if (rsp_closes_signature !== want.closes)
                  report_mismatch("closes_signature", 64'(rsp_closes_signature),
                                  64'(want.closes));
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last_of_run", 64'(rsp_last_of_run), 64'(want.last));
            end
            words_seen++;
         end

         if (csr_write_en) apply_reg(csr_index, csr_data);

         if (req_valid && req_ready) begin
            n0 = expected_words.size();
            pack_symbol(req_symbol, req_end_of_signature);
            // directed rows with a typed-in answer replace the predicted words
            if (cur_row >= 0 && stim_rows[cur_row].n_typed >= 0) begin
               r = stim_rows[cur_row];
               while (expected_words.size() > n0) void'(expected_words.pop_back());
               if (r.n_typed >= 1) push_word(r.w0, r.c0, r.n_typed == 1);
               if (r.n_typed >= 2) push_word(r.w1, r.c1, 1'b1);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // directed table
   // ------------------------------------------------------------------

   function automatic stim_row_type r_csr(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r         = '{default: '0};
      r.is_csr  = 1'b1;
      r.idx     = idx;
      r.data    = data;
      r.n_typed = -1;
      return r;
   endfunction

   function automatic stim_row_type r_chk(input logic [SYMBOL_W-1:0] sym, input bit eos,
                                          input int n, input logic [63:0] w0, input bit c0,
                                          input logic [63:0] w1, input bit c1);
      stim_row_type r;
      r         = '{default: '0};
      r.sym     = sym;
      r.eos     = eos;
      r.n_typed = n;
      r.w0      = w0;
      r.c0      = c0;
      r.w1      = w1;
      r.c1      = c1;
      return r;
   endfunction

   function automatic stim_row_type r_sym(input logic [SYMBOL_W-1:0] sym, input bit eos);
      return r_chk(sym, eos, -1, '0, 1'b0, '0, 1'b0);
   endfunction

   function automatic void build_rows();
      // reset setting: 2-bit symbol, then terminator, top of a 64-bit word
      stim_rows.push_back(r_chk(8'hFF, 1'b1, 1, 64'hC000_0000_0000_0000, 1, '0, 0));
      // fixed length one, 8-bit symbols in 8-bit words: every symbol is a word
      stim_rows.push_back(r_csr(REG_SYMBOL_BITS, 8'd8));
      stim_rows.push_back(r_csr(REG_WORD_BITS, 8'd8));
      stim_rows.push_back(r_csr(REG_SYMBOLS_PER_SIG, 8'd1));
      stim_rows.push_back(r_chk(8'hA5, 1'b0, 1, 64'hA5, 1, '0, 0));
      stim_rows.push_back(r_chk(8'h00, 1'b1, 1, 64'h00, 1, '0, 0));   // end flag ignored
      stim_rows.push_back(r_chk(8'hFF, 1'b0, 1, 64'hFF, 1, '0, 0));
      // variable mode, symbol fills the word so the terminator gets its own
      stim_rows.push_back(r_csr(REG_SYMBOLS_PER_SIG, 8'd0));
      stim_rows.push_back(r_chk(8'h5A, 1'b1, 2, 64'h5A, 0, 64'h0, 1));
      // zero widths clamp up to a 1-bit symbol in a 1-bit word
      stim_rows.push_back(r_csr(REG_SYMBOL_BITS, 8'd0));
      stim_rows.push_back(r_csr(REG_WORD_BITS, 8'd0));
      stim_rows.push_back(r_chk(8'hFF, 1'b0, 1, 64'h1, 0, '0, 0));
      stim_rows.push_back(r_chk(8'hFE, 1'b1, 2, 64'h0, 0, 64'h0, 1));
      // all-ones data: symbol width clamps to 8, word width to 64, length 255
      stim_rows.push_back(r_csr(REG_SYMBOL_BITS, 8'hFF));
      stim_rows.push_back(r_csr(REG_WORD_BITS, 8'hFF));
      stim_rows.push_back(r_csr(REG_SYMBOLS_PER_SIG, 8'hFF));
      stim_rows.push_back(r_sym(8'h12, 1'b1));
      // unused index must not disturb the partial word
      stim_rows.push_back(r_csr(REG_UNUSED, 8'hFF));
      stim_rows.push_back(r_sym(8'h34, 1'b0));
      // write drops the partial word; 3-bit symbols in 10-bit words
      stim_rows.push_back(r_csr(REG_SYMBOL_BITS, 8'd3));
      stim_rows.push_back(r_csr(REG_WORD_BITS, 8'd10));
      stim_rows.push_back(r_csr(REG_SYMBOLS_PER_SIG, 8'd0));
      stim_rows.push_back(r_sym(8'h05, 1'b0));
      stim_rows.push_back(r_sym(8'h07, 1'b0));
      stim_rows.push_back(r_sym(8'h01, 1'b1));   // closes by fill, then lone terminator
      // count and fill reach the limit on the same symbol
      stim_rows.push_back(r_csr(REG_SYMBOLS_PER_SIG, 8'd2));
      stim_rows.push_back(r_csr(REG_SYMBOL_BITS, 8'd4));
      stim_rows.push_back(r_csr(REG_WORD_BITS, 8'd8));
      stim_rows.push_back(r_sym(8'h0C, 1'b0));
      stim_rows.push_back(r_sym(8'h03, 1'b1));
   endfunction

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------

   // present one symbol on req and hold it until taken
   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input bit eos, input int row);
      int gap;
      // stretches of back-to-back traffic between the random gaps
      gap = ((items_sent % 160) < 30) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_symbol           <= sym;
      req_end_of_signature <= eos;
      cur_row              <= row;
      do @(posedge clock); while (!(req_valid && req_ready));
      items_sent++;
   endtask

   // registers change only once the pipeline has drained
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      // symbols that close no word may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int ph;
      int k;
      int sb;
      int wb;
      int spl;
      int sig_left;
      bit broken;
      bit eos;
      reset                <= 1'b1;
      csr_write_en         <= 1'b0;
      csr_index            <= REG_SYMBOL_BITS;
      csr_data             <= '0;
      req_valid            <= 1'b0;
      req_symbol           <= '0;
      req_end_of_signature <= 1'b0;
      cur_row              <= -1;
      sig_left = 0;
      broken   = 0;
      build_rows();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_csr) begin
            write_reg(stim_rows[i].idx, stim_rows[i].data);
            settings_used++;
         end else begin
            send_symbol(stim_rows[i].sym, stim_rows[i].eos, i);
         end
      end

      // random part: one register setting per phase, extremes first
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin sb = 1; wb = 64; spl = 0;   end
            1: begin sb = 8; wb = 64; spl = 255; end
            2: begin sb = 8; wb = 8;  spl = 0;   end
            3: begin sb = 1; wb = 1;  spl = 1;   end
            default: begin
               sb  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
               wb  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range((sb > 8) ? 8 : sb, 64);
               spl = ($urandom_range(0, 1) == 0) ? 0 :
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(1, 20);
            end
         endcase
         // junk in the unused upper data bits is masked off
         write_reg(REG_SYMBOL_BITS, (8'($urandom) & 8'hF0) | 8'(sb));
         write_reg(REG_WORD_BITS, (8'($urandom) & 8'h80) | 8'(wb));
         write_reg(REG_SYMBOLS_PER_SIG, 8'(spl));
         settings_used++;
         sig_left = 0;

         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (spl == 0) begin
               // mostly well-formed signatures, now and then a broken one
               if (sig_left == 0) begin
                  sig_left = $urandom_range(1, 12);
                  broken   = ($urandom_range(0, 7) == 0);
               end
               eos = broken ? 1'($urandom_range(0, 1)) : (sig_left == 1);
               sig_left--;
            end else begin
               // end flag means nothing in fixed mode, so it is pure noise
               eos = 1'($urandom_range(0, 1));
            end
            send_symbol(8'($urandom_range(0, 255)), eos, -1);
         end
      end

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d symbols packed into %0d checked words over %0d register settings",
               items_sent, words_seen, settings_used);
      $display("fixed and variable signatures, clamped widths, long output hold-off");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // receiver side
   // ------------------------------------------------------------------

   initial begin
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!pressure_done && items_sent >= PRESSURE_AT) begin
            // long hold-off so the block backs up and drops req_ready
            gap           = HOLD_CYCLES;
            pressure_done = 1;
         end else if ((words_seen % 140) < 25) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 18);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #4000000;
      $display("timeout with %0d words still expected", expected_words.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
